/* sv/mtms_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the multitrack event merge scheduler.
// Depends on nothing; every other file imports it.
package mtms_pkg;

    // Item codes
    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_STEP  = 2'd2,
        KIND_SEEK  = 2'd3
    } kind_t;

    // Event type codes; other codes are meta events that get dropped
    localparam logic [1:0] ETYPE_CHANNEL = 2'd0;
    localparam logic [1:0] ETYPE_TEMPO   = 2'd1;

    localparam logic [15:0] TPQ_RESET     = 16'd96;
    localparam logic [23:0] TEMPO_RESET   = 24'd5208;
    localparam logic [23:0] US_PER_QUARTER = 24'd500000;
    localparam logic [31:0] TIME_MAX      = 32'hFFFF_FFFF;
    localparam logic [31:0] END_WAIT_TICKS = 32'd16;
    localparam logic [16:0] FRAC_ONE      = 17'd65536;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  track;
        logic [27:0] delta_ticks;
        logic [1:0]  event_type;
        logic [23:0] payload;
        logic [1:0]  payload_len;
        logic [16:0] seek_fraction;
    } item_t;

    typedef struct packed {
        logic        message_valid;
        logic [23:0] message;
        logic [1:0]  message_len;
        logic [3:0]  chosen_track;
        logic        tempo_changed;
        logic [55:0] wait_us;
        logic        finished;
    } result_t;

    // One stored event
    typedef struct packed {
        logic [27:0] delta;
        logic [31:0] abs_time;
        logic [1:0]  etype;
        logic [1:0]  plen;
        logic [23:0] payload;
    } ev_word_t;

    typedef struct packed {
        logic        start;
        logic [23:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [23:0] quotient;
    } div_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LD,
        ST_LD_WR,
        ST_CLR,
        ST_CLR_WAIT,
        ST_CH_RD,
        ST_CH_WR,
        ST_MIN,
        ST_GAP_RD,
        ST_GAP,
        ST_EV_RD,
        ST_MUL,
        ST_TEMPO,
        ST_TEMPO_WAIT,
        ST_POST,
        ST_DONE,
        ST_SK_MUL,
        ST_SK_TGT,
        ST_SK_RD,
        ST_SK_CHK
    } state_t;

endpackage

/* sv/mtms_divider.sv */
`timescale 1ns / 1ps
// Restoring radix-2 divider, 24-bit dividend by 16-bit divisor, one bit a cycle.
// Depends on mtms_pkg for the request and response structs.
module mtms_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  mtms_pkg::div_req_t req,
    output mtms_pkg::div_rsp_t rsp
);
    import mtms_pkg::*;

    logic [16:0] rem_reg, rem_next;
    logic [23:0] quo_reg, quo_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] rem_sh;

    // Shift one dividend bit in and try a subtract
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[15:0], quo_reg[23]};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = (req.divisor == 16'd0) ? 16'd1 : req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = rem_sh - {1'b0, dvs_reg};
                quo_next = {quo_reg[22:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[22:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd23)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

/* sv/mtms_store.sv */
`timescale 1ns / 1ps
// Event memory: one write port, one registered read port.
// Depends on mtms_pkg for the event word type.
module mtms_store #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  mtms_pkg::ev_word_t  wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output mtms_pkg::ev_word_t  rd_data
);
    import mtms_pkg::*;

    ev_word_t mem [DEPTH];
    ev_word_t rd_data_reg;

    // Write and read; read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/multitrack_event_merge_scheduler_unit.sv */
`timescale 1ns / 1ps
// Top level of the multitrack event merge scheduler: sequencer, track state,
// shared multiplier. Depends on mtms_pkg, mtms_store and mtms_divider.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------
//  item     | item_valid / item_stall | item   (mtms_pkg::item_t)
//  result   | result_valid / _stall   | result (mtms_pkg::result_t)
//  config   | cfg_valid / cfg_ready   | cfg_data (ticks per quarter)
//
// Load reads the previous time and writes the event; clear runs the divider; a step
// scans the tracks to charge, pick and gap, and runs the divider on a tempo event;
// seek scans each track's stored events in turn through the memory read port.
// Reset clears track counts, positions and times and sets the default tempo at once; no memory pass.
// item_stall is high whenever the sequencer is busy; a result waits in its
// output register while the next item is taken.
module multitrack_event_merge_scheduler_unit #(
    parameter int TRACK_COUNT      = 16,
    parameter int EVENTS_PER_TRACK = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  mtms_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output mtms_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [15:0]       cfg_data
);
    import mtms_pkg::*;

    localparam int DEPTH = TRACK_COUNT * EVENTS_PER_TRACK;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TIW   = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
    localparam int CW    = $clog2(EVENTS_PER_TRACK) + 1;
    localparam logic [TIW-1:0] LAST_T = TIW'(TRACK_COUNT - 1);
    localparam logic [CW-1:0]  EPT    = CW'(EVENTS_PER_TRACK);

    function automatic logic [AW-1:0] addr_of(input logic [TIW-1:0] t,
                                              input logic [CW-1:0] p);
        addr_of = AW'(t) * AW'(EVENTS_PER_TRACK) + AW'(p);
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = s[32] ? TIME_MAX : s[31:0];
    endfunction

    state_t state_reg, state_next;
    item_t  item_reg, item_next;

    logic [CW-1:0] cnt_reg  [TRACK_COUNT];
    logic [CW-1:0] cnt_next [TRACK_COUNT];
    logic [CW-1:0] pos_reg  [TRACK_COUNT];
    logic [CW-1:0] pos_next [TRACK_COUNT];
    logic [31:0]   time_reg  [TRACK_COUNT];
    logic [31:0]   time_next [TRACK_COUNT];
    logic [TRACK_COUNT-1:0] chg_reg, chg_next;

    logic [31:0]    end_reg, end_next;
    logic [23:0]    tempo_reg, tempo_next;
    logic [15:0]    tpq_reg, tpq_next;
    logic [TIW-1:0] scan_reg, scan_next;
    logic [CW-1:0]  k_reg, k_next;
    logic           found_reg, found_next;
    logic [TIW-1:0] chosen_reg, chosen_next;
    logic [31:0]    min_reg, min_next;
    logic           hgap_reg, hgap_next;
    logic [31:0]    gap_reg, gap_next;
    logic [31:0]    target_reg, target_next;
    logic [55:0]    prod_reg, prod_next;
    result_t        build_reg, build_next;
    result_t        res_reg, res_next;
    logic           rv_reg, rv_next;

    logic [31:0] mul_a;
    logic [23:0] mul_b;
    logic [55:0] mul_p;
    logic [31:0] cand;
    logic [TIW-1:0] ld_t;
    logic [31:0] ld_abs;

    logic       wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    ev_word_t   wr_data, rd_data;
    div_req_t   dreq;
    div_rsp_t   drsp;

    mtms_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
    );

    mtms_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // Shared multiplier: wait time on steps, seek target on seeks
    always_comb
    begin
        if (state_reg == ST_SK_MUL)
        begin
            mul_a = end_reg;
            mul_b = (item_reg.seek_fraction > FRAC_ONE) ? 24'(FRAC_ONE)
                                                        : 24'(item_reg.seek_fraction);
        end
        else
        begin
            mul_a = hgap_reg ? gap_reg : END_WAIT_TICKS;
            mul_b = tempo_reg;
        end
    end

    assign mul_p = 56'(mul_a) * 56'(mul_b);

    assign ld_t   = TIW'(item_reg.track);
    assign ld_abs = sat_add((cnt_reg[ld_t] != '0) ? rd_data.abs_time : 32'd0,
                            32'(item_reg.delta_ticks));

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        time_next   = time_reg;
        chg_next    = chg_reg;
        end_next    = end_reg;
        tempo_next  = tempo_reg;
        tpq_next    = tpq_reg;
        scan_next   = scan_reg;
        k_next      = k_reg;
        found_next  = found_reg;
        chosen_next = chosen_reg;
        min_next    = min_reg;
        hgap_next   = hgap_reg;
        gap_next    = gap_reg;
        target_next = target_reg;
        prod_next   = prod_reg;
        build_next  = build_reg;
        res_next    = res_reg;
        rv_next     = rv_reg;
        wr_en       = 1'b0;
        wr_addr     = addr_of(ld_t, cnt_reg[ld_t]);
        wr_data     = '{delta: item_reg.delta_ticks, abs_time: ld_abs,
                        etype: item_reg.event_type, plen: item_reg.payload_len,
                        payload: item_reg.payload};
        rd_en       = 1'b0;
        rd_addr     = addr_of(ld_t, cnt_reg[ld_t] - CW'(1));
        dreq        = '{start: 1'b0, dividend: US_PER_QUARTER, divisor: tpq_reg};
        cand        = time_reg[scan_reg] - min_reg;

        // Drop the result once taken
        if (rv_reg && !result_stall)
            rv_next = 1'b0;
        if (cfg_valid)
            tpq_next = cfg_data;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_next = item;
                    scan_next = '0;
                    case (kind_t'(item.kind))
                        KIND_LOAD:  state_next = ST_LD;
                        KIND_CLEAR: state_next = ST_CLR;
                        KIND_STEP:  state_next = ST_CH_RD;
                        KIND_SEEK:  state_next = ST_SK_MUL;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            // Fetch the previous absolute time of the track
            ST_LD:
            begin
                if ((32'(item_reg.track) < TRACK_COUNT) && (cnt_reg[ld_t] < EPT))
                begin
                    rd_en      = (cnt_reg[ld_t] != '0);
                    state_next = ST_LD_WR;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_LD_WR:
            begin
                wr_en = 1'b1;
                cnt_next[ld_t] = cnt_reg[ld_t] + CW'(1);
                if (ld_abs > end_reg)
                    end_next = ld_abs;
                state_next = ST_IDLE;
            end
            ST_CLR:
            begin
                dreq.start = 1'b1;
                for (int t = 0; t < TRACK_COUNT; t++)
                begin
                    cnt_next[t]  = '0;
                    pos_next[t]  = '0;
                    time_next[t] = '0;
                end
                chg_next   = '0;
                end_next   = '0;
                state_next = ST_CLR_WAIT;
            end
            ST_CLR_WAIT:
            begin
                if (drsp.done)
                begin
                    tempo_next = drsp.quotient;
                    state_next = ST_IDLE;
                end
            end
            // Charge unread heads with their delta
            ST_CH_RD:
            begin
                rd_addr = addr_of(scan_reg, pos_reg[scan_reg]);
                if ((pos_reg[scan_reg] < cnt_reg[scan_reg]) && !chg_reg[scan_reg])
                begin
                    rd_en      = 1'b1;
                    state_next = ST_CH_WR;
                end
                else if (scan_reg == LAST_T)
                begin
                    scan_next  = '0;
                    found_next = 1'b0;
                    state_next = ST_MIN;
                end
                else
                    scan_next = scan_reg + TIW'(1);
            end
            ST_CH_WR:
            begin
                time_next[scan_reg] = sat_add(time_reg[scan_reg], 32'(rd_data.delta));
                chg_next[scan_reg]  = 1'b1;
                state_next = ST_CH_RD;
                if (scan_reg == LAST_T)
                begin
                    scan_next  = '0;
                    found_next = 1'b0;
                    state_next = ST_MIN;
                end
                else
                    scan_next = scan_reg + TIW'(1);
            end
            // Pick the smallest time; ties go to the higher index
            ST_MIN:
            begin
                if ((pos_reg[scan_reg] < cnt_reg[scan_reg]) &&
                    (!found_reg || (time_reg[scan_reg] <= min_reg)))
                begin
                    found_next  = 1'b1;
                    chosen_next = scan_reg;
                    min_next    = time_reg[scan_reg];
                end
                hgap_next = 1'b0;
                if (scan_reg == LAST_T)
                begin
                    scan_next  = '0;
                    state_next = (found_next) ? ST_GAP_RD : ST_MUL;
                end
                else
                    scan_next = scan_reg + TIW'(1);
            end
            ST_GAP_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = addr_of(chosen_reg, pos_reg[chosen_reg] + CW'(1));
                state_next = ST_GAP;
            end
            // Find the smallest gap to the next event
            ST_GAP:
            begin
                if (pos_reg[scan_reg] < cnt_reg[scan_reg])
                begin
                    if (scan_reg == chosen_reg)
                    begin
                        if ((pos_reg[scan_reg] + CW'(1)) < cnt_reg[scan_reg])
                        begin
                            cand = 32'(rd_data.delta);
                            if (!hgap_reg || (cand < gap_reg))
                            begin
                                gap_next  = cand;
                                hgap_next = 1'b1;
                            end
                        end
                    end
                    else if (!hgap_reg || (cand < gap_reg))
                    begin
                        gap_next  = cand;
                        hgap_next = 1'b1;
                    end
                end
                if (scan_reg == LAST_T)
                    state_next = ST_EV_RD;
                else
                    scan_next = scan_reg + TIW'(1);
            end
            ST_EV_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = addr_of(chosen_reg, pos_reg[chosen_reg]);
                state_next = ST_MUL;
            end
            // Compute the wait and build the result
            ST_MUL:
            begin
                build_next = '0;
                build_next.wait_us = mul_p;
                if (!found_reg)
                begin
                    build_next.finished = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    build_next.chosen_track = 4'(chosen_reg);
                    state_next = ST_POST;
                    if (rd_data.etype == ETYPE_CHANNEL)
                    begin
                        build_next.message_valid = 1'b1;
                        build_next.message       = rd_data.payload;
                        build_next.message_len   = rd_data.plen;
                    end
                    else if (rd_data.etype == ETYPE_TEMPO)
                    begin
                        build_next.tempo_changed = 1'b1;
                        state_next = ST_TEMPO;
                    end
                end
            end
            ST_TEMPO:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = rd_data.payload;
                state_next    = ST_TEMPO_WAIT;
            end
            ST_TEMPO_WAIT:
            begin
                if (drsp.done)
                begin
                    tempo_next = drsp.quotient;
                    state_next = ST_POST;
                end
            end
            // Advance the chosen track
            ST_POST:
            begin
                chg_next[chosen_reg] = 1'b0;
                pos_next[chosen_reg] = pos_reg[chosen_reg] + CW'(1);
                state_next = ST_DONE;
            end
            // Hand the beat to the output register once it is free
            ST_DONE:
            begin
                if (!rv_reg || !result_stall)
                begin
                    res_next   = build_reg;
                    rv_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SK_MUL:
            begin
                prod_next  = mul_p;
                state_next = ST_SK_TGT;
            end
            ST_SK_TGT:
            begin
                target_next = prod_reg[47:16];
                scan_next   = '0;
                k_next      = '0;
                state_next  = ST_SK_RD;
            end
            // Scan each track for its first event at or after the target
            ST_SK_RD:
            begin
                rd_addr = addr_of(scan_reg, k_reg);
                if (k_reg < cnt_reg[scan_reg])
                begin
                    rd_en      = 1'b1;
                    state_next = ST_SK_CHK;
                end
                else
                begin
                    k_next = '0;
                    if (scan_reg == LAST_T)
                        state_next = ST_IDLE;
                    else
                        scan_next = scan_reg + TIW'(1);
                end
            end
            ST_SK_CHK:
            begin
                state_next = ST_SK_RD;
                if (rd_data.abs_time >= target_reg)
                begin
                    pos_next[scan_reg]  = k_reg;
                    chg_next[scan_reg]  = 1'b1;
                    time_next[scan_reg] = rd_data.abs_time;
                    k_next = '0;
                    if (scan_reg == LAST_T)
                        state_next = ST_IDLE;
                    else
                        scan_next = scan_reg + TIW'(1);
                end
                else
                    k_next = k_reg + CW'(1);
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int t = 0; t < TRACK_COUNT; t++)
            begin
                cnt_reg[t]  <= '0;
                pos_reg[t]  <= '0;
                time_reg[t] <= '0;
            end
            chg_reg   <= '0;
            end_reg   <= '0;
            tempo_reg <= TEMPO_RESET;
            tpq_reg   <= TPQ_RESET;
            rv_reg    <= 1'b0;
            scan_reg  <= '0;
            k_reg     <= '0;
            found_reg <= 1'b0;
            hgap_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pos_reg   <= pos_next;
            time_reg  <= time_next;
            chg_reg   <= chg_next;
            end_reg   <= end_next;
            tempo_reg <= tempo_next;
            tpq_reg   <= tpq_next;
            rv_reg    <= rv_next;
            scan_reg  <= scan_next;
            k_reg     <= k_next;
            found_reg <= found_next;
            hgap_reg  <= hgap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        chosen_reg <= chosen_next;
        min_reg    <= min_next;
        gap_reg    <= gap_next;
        target_reg <= target_next;
        prod_reg   <= prod_next;
        build_reg  <= build_next;
        res_reg    <= res_next;
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = rv_reg;
    assign result       = res_reg;
    assign cfg_ready    = 1'b1;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("block not busy after taking an item");
    a_chosen_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GAP) |-> (found_reg && (pos_reg[chosen_reg] < cnt_reg[chosen_reg])))
        else $error("chosen track has no event");
    a_finished_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rv_reg && res_reg.finished) |-> (!res_reg.message_valid && !res_reg.tempo_changed))
        else $error("finished result carries an event");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !drsp.busy)
        else $error("divider busy while idle");
`endif

endmodule
